/* rtl/erm_pkg.sv */
// Shared types, constants and register indexes of the event rate EMA meter.
`default_nettype none

package erm_pkg;

    localparam int COUNT_WIDTH   = 48;
    localparam int FRACTION_BITS = 16;

    localparam int AMOUNT_W    = 32;
    localparam int AVG_W       = 48;
    localparam int SCALE_W     = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int RATE_SHIFT  = FRACTION_BITS - 8;
    localparam int PROD_W      = COUNT_WIDTH + SCALE_W;
    localparam int DIFF_W      = AVG_W + 1;
    localparam int WPROD_W     = DIFF_W + WEIGHT_BITS + 1;

    localparam int NUM_AVG   = 4;
    localparam int AVG_IDX_W = $clog2(NUM_AVG);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE_SCALE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_MINUTE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_TEN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_HOUR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_WINDOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_ENABLE = 3'd5;

    localparam logic [AVG_IDX_W-1:0] AVG_MINUTE = 2'd0;
    localparam logic [AVG_IDX_W-1:0] AVG_TEN    = 2'd1;
    localparam logic [AVG_IDX_W-1:0] AVG_HOUR   = 2'd2;
    localparam logic [AVG_IDX_W-1:0] AVG_WINDOW = 2'd3;

    localparam logic [AVG_W-1:0] AVG_POS_MAX = {1'b0, {(AVG_W-1){1'b1}}};
    localparam logic [AVG_W-1:0] AVG_NEG_MAG = {1'b1, {(AVG_W-1){1'b0}}};
    localparam logic [AVG_W-1:0] RATE_POS_LIM = AVG_POS_MAX >> RATE_SHIFT;
    localparam logic [AVG_W-1:0] RATE_NEG_LIM = AVG_NEG_MAG >> RATE_SHIFT;

    localparam logic [SCALE_W-1:0] RESET_RATE_SCALE    = 16'd256;
    localparam logic [SCALE_W-1:0] RESET_WEIGHT_MINUTE = 16'd41427;
    localparam logic [SCALE_W-1:0] RESET_WEIGHT_TEN    = 16'd6237;
    localparam logic [SCALE_W-1:0] RESET_WEIGHT_HOUR   = 16'd1083;

    typedef struct packed {
        logic signed [AMOUNT_W-1:0] amount;
        logic                       tick;
    } t_in_item;

    typedef struct packed {
        logic signed [AVG_W-1:0] count_value;
        logic signed [AVG_W-1:0] avg_minute;
        logic signed [AVG_W-1:0] avg_ten_minutes;
        logic signed [AVG_W-1:0] avg_hour;
        logic signed [AVG_W-1:0] avg_window;
    } t_out_item;

    typedef struct packed {
        logic                   tick;
        logic [COUNT_WIDTH-1:0] count;
    } t_entry;

    typedef struct packed {
        logic [SCALE_W-1:0]     rate_scale;
        logic [WEIGHT_BITS-1:0] weight_minute;
        logic [WEIGHT_BITS-1:0] weight_ten_minutes;
        logic [WEIGHT_BITS-1:0] weight_hour;
        logic [WEIGHT_BITS-1:0] weight_window;
        logic                   window_enable;
    } t_cfg;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

`default_nettype wire

/* rtl/event_rate_ema_meter.sv */
// Top level of the event rate EMA meter: configuration registers and datapath wiring.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): each transfer adds a signed
// amount to the running count; an item with tick set also scales the count change
// since the previous tick to a per-minute rate and moves the four averages toward it.
// Output channel (o_out_valid / i_out_stall / o_out_data): one transfer per input
// item, in order, carrying the count and the four averages after that item.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index at the clock
// edge; write only while no item is in flight. Unknown indexes are ignored.
// Latency: an item without tick passes through the queue to the output register;
// a tick item goes through 5 rate steps, the single shared multiply-accumulate
// unit updating the averages one after another (difference, weight multiply and accumulate each), and the result load.
// Throughput: one item per cycle while no tick is in progress and the output is not
// stalled; a tick keeps the back end busy, and the 4-entry queue absorbs input
// meanwhile before o_in_stall rises.
// Reset (synchronous, active low) clears the count, tick reference, averages and
// queue, and loads the default weights and rate scale.
// A stalled output holds its result; the back end waits and the queue fills, then
// the input side stalls.
`default_nettype none

module event_rate_ema_meter import erm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg          r_cfg;
    t_queue_status status;
    t_entry        push_entry;
    t_entry        head;
    logic          push;
    logic          pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_scale         <= RESET_RATE_SCALE;
            r_cfg.weight_minute      <= RESET_WEIGHT_MINUTE;
            r_cfg.weight_ten_minutes <= RESET_WEIGHT_TEN;
            r_cfg.weight_hour        <= RESET_WEIGHT_HOUR;
            r_cfg.weight_window      <= '0;
            r_cfg.window_enable      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RATE_SCALE:    r_cfg.rate_scale         <= i_cfg_data;
                CFG_WEIGHT_MINUTE: r_cfg.weight_minute      <= i_cfg_data;
                CFG_WEIGHT_TEN:    r_cfg.weight_ten_minutes <= i_cfg_data;
                CFG_WEIGHT_HOUR:   r_cfg.weight_hour        <= i_cfg_data;
                CFG_WEIGHT_WINDOW: r_cfg.weight_window      <= i_cfg_data;
                CFG_WINDOW_ENABLE: r_cfg.window_enable      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    erm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_status   (status),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    erm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (status)
    );

    erm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (head),
        .i_status    (status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

/* rtl/erm_front.sv */
// Front end: accepts input transfers, keeps the running count, queues each item.
`default_nettype none

module erm_front import erm_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire t_in_item      i_in_data,
    input  wire t_queue_status i_status,
    output logic               o_push,
    output t_entry             o_entry
);

    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;

    assign o_in_stall = i_status.full;
    assign o_push     = i_in_valid && !i_status.full;
    assign n_count    = r_count + COUNT_WIDTH'(i_in_data.amount);

    assign o_entry.tick  = i_in_data.tick;
    assign o_entry.count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

/* rtl/erm_queue.sv */
// Short FIFO between the front end and the averaging back end.
`default_nettype none

module erm_queue import erm_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output t_entry      o_head,
    output t_queue_status o_status
);

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_fill;

    assign o_head          = r_mem[r_rd_ptr];
    assign o_status.empty  = (r_fill == '0);
    assign o_status.full   = (r_fill == (QPTR_W+1)'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("queue pop while empty");

endmodule

`default_nettype wire

/* rtl/erm_back.sv */
// Back end: scales the tick delta to a rate, updates the averages, drives results.
`default_nettype none

module erm_back import erm_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cfg          i_cfg,
    input  wire t_entry        i_head,
    input  wire t_queue_status i_status,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output t_out_item          o_out_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DELTA,
        S_MAG,
        S_MUL,
        S_SAT,
        S_NEG,
        S_DIFF,
        S_WMUL,
        S_ACC,
        S_DONE
    } t_state;

    t_state                     r_state;
    logic                       r_out_valid;
    t_out_item                  r_out;
    logic [COUNT_WIDTH-1:0]     r_cur_count;
    logic [COUNT_WIDTH-1:0]     r_last;
    logic [COUNT_WIDTH-1:0]     r_delta;
    logic [COUNT_WIDTH-1:0]     r_mag;
    logic                       r_neg;
    logic [PROD_W-1:0]          r_prod;
    logic [AVG_W-1:0]           r_rmag;
    logic signed [AVG_W-1:0]    r_rate;
    logic signed [AVG_W-1:0]    r_avg [NUM_AVG];
    logic [AVG_IDX_W-1:0]       r_idx;
    logic signed [DIFF_W-1:0]   r_diff;
    logic [WEIGHT_BITS-1:0]     r_w;
    logic signed [WPROD_W-1:0]  r_wprod;

    logic                       out_load;
    logic                       out_set;
    logic [WEIGHT_BITS-1:0]     n_w;
    logic [AVG_W-1:0]           n_rmag;
    logic signed [AVG_W-1:0]    n_avg;

    assign out_load = !r_out_valid || !i_out_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_status.empty && (i_head.tick || out_load);
    assign out_set  = ((r_state == S_IDLE) && o_pop && !i_head.tick)
                   || ((r_state == S_DONE) && out_load);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        case (r_idx)
            AVG_MINUTE: n_w = i_cfg.weight_minute;
            AVG_TEN:    n_w = i_cfg.weight_ten_minutes;
            AVG_HOUR:   n_w = i_cfg.weight_hour;
            AVG_WINDOW: n_w = i_cfg.window_enable ? i_cfg.weight_window : '0;
            default:    n_w = '0;
        endcase
    end

    always_comb begin
        if (r_neg) begin
            n_rmag = (r_prod > PROD_W'(RATE_NEG_LIM)) ? AVG_NEG_MAG
                                                      : (AVG_W'(r_prod) << RATE_SHIFT);
        end else begin
            n_rmag = (r_prod > PROD_W'(RATE_POS_LIM)) ? AVG_POS_MAX
                                                      : (AVG_W'(r_prod) << RATE_SHIFT);
        end
    end

    assign n_avg = r_avg[r_idx] + AVG_W'(r_wprod >>> WEIGHT_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_last      <= '0;
            r_idx       <= '0;
            for (int k = 0; k < NUM_AVG; k++) begin
                r_avg[k] <= '0;
            end
        end else begin
            if (out_set) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (i_head.tick) begin
                            r_cur_count <= i_head.count;
                            r_state     <= S_DELTA;
                        end else begin
                            r_out.count_value     <= AVG_W'(signed'(i_head.count));
                            r_out.avg_minute      <= r_avg[AVG_MINUTE];
                            r_out.avg_ten_minutes <= r_avg[AVG_TEN];
                            r_out.avg_hour        <= r_avg[AVG_HOUR];
                            r_out.avg_window      <= r_avg[AVG_WINDOW];
                        end
                    end
                end
                S_DELTA: begin
                    r_delta <= r_cur_count - r_last;
                    r_last  <= r_cur_count;
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_neg   <= r_delta[COUNT_WIDTH-1];
                    r_mag   <= r_delta[COUNT_WIDTH-1] ? (~r_delta + 1'b1) : r_delta;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= r_mag * i_cfg.rate_scale;
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_rmag  <= n_rmag;
                    r_state <= S_NEG;
                end
                S_NEG: begin
                    r_rate  <= r_neg ? signed'(~r_rmag + 1'b1) : signed'(r_rmag);
                    r_idx   <= '0;
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_diff  <= DIFF_W'(r_rate) - DIFF_W'(r_avg[r_idx]);
                    r_w     <= n_w;
                    r_state <= S_WMUL;
                end
                S_WMUL: begin
                    r_wprod <= r_diff * signed'({1'b0, r_w});
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_avg[r_idx] <= n_avg;
                    if (r_idx == AVG_WINDOW) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_DIFF;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out.count_value     <= AVG_W'(signed'(r_cur_count));
                        r_out.avg_minute      <= r_avg[AVG_MINUTE];
                        r_out.avg_ten_minutes <= r_avg[AVG_TEN];
                        r_out.avg_hour        <= r_avg[AVG_HOUR];
                        r_out.avg_window      <= r_avg[AVG_WINDOW];
                        r_state               <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE))
        else $error("queue popped while an update is in progress");

    a_window_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC && r_idx == AVG_WINDOW && !i_cfg.window_enable)
        |=> $stable(r_avg[AVG_WINDOW]))
        else $error("window average moved while disabled");

    a_loop_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NEG) |=> (r_state == S_DIFF && r_idx == AVG_MINUTE))
        else $error("average loop did not start at the first average");

endmodule

`default_nettype wire

/* verif/erm_checker.sv */
// Checker for the event rate EMA meter: tracks config writes, predicts readings, compares.
`timescale 1ns / 1ps

module erm_checker import erm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_item             i_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches = 0,
    output int                    o_pending = 0
);

    t_cfg                   cfg;
    logic [COUNT_WIDTH-1:0] event_count;
    logic [COUNT_WIDTH-1:0] tick_count;
    longint                 level [NUM_AVG];
    t_out_item              meter_readings_q [$];
    int                     mismatch_total = 0;

    function automatic longint minute_rate(logic [COUNT_WIDTH-1:0] delta,
                                           logic [SCALE_W-1:0] scale);
        logic                   neg;
        logic [COUNT_WIDTH-1:0] neg_delta;
        logic [63:0]            mag;
        logic [63:0]            prod;
        logic [63:0]            cap;
        neg = delta[COUNT_WIDTH-1];
        neg_delta = -delta;
        mag = neg ? neg_delta : delta;
        cap = neg ? 64'(AVG_NEG_MAG) : 64'(AVG_POS_MAX);
        if (mag == 0 || scale == 0) begin
            return 0;
        end
        prod = mag * scale;
        if (prod > ((64'd1 << AVG_W) >> RATE_SHIFT)) begin
            prod = cap;
        end else begin
            prod = prod << RATE_SHIFT;
        end
        if (prod > cap) begin
            prod = cap;
        end
        return neg ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic longint ema_step(longint avg, longint rate,
                                        logic [WEIGHT_BITS-1:0] weight);
        longint diff;
        longint hi;
        longint lo;
        longint wt;
        wt = longint'(weight);
        diff = rate - avg;
        hi = diff >>> WEIGHT_BITS;
        lo = diff - hi * 65536;
        return avg + wt * hi + ((wt * lo) >>> WEIGHT_BITS);
    endfunction

    task automatic check_field(string name, logic [AVG_W-1:0] want, logic [AVG_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            mismatch_total++;
        end
    endtask

    always @(posedge i_clk) begin : track
        t_out_item              reading;
        logic [COUNT_WIDTH-1:0] amount_ext;
        longint                 rate;
        if (!i_rst_n) begin
            cfg = '{rate_scale: RESET_RATE_SCALE, weight_minute: RESET_WEIGHT_MINUTE,
                    weight_ten_minutes: RESET_WEIGHT_TEN, weight_hour: RESET_WEIGHT_HOUR,
                    weight_window: '0, window_enable: 1'b0};
            event_count = '0;
            tick_count = '0;
            foreach (level[k]) level[k] = 0;
            meter_readings_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (meter_readings_q.size() == 0) begin
                    $error("output transfer with no reading expected");
                    mismatch_total++;
                end else begin
                    reading = meter_readings_q.pop_front();
                    check_field("count_value", reading.count_value, i_out_data.count_value);
                    check_field("avg_minute", reading.avg_minute, i_out_data.avg_minute);
                    check_field("avg_ten_minutes", reading.avg_ten_minutes,
                                i_out_data.avg_ten_minutes);
                    check_field("avg_hour", reading.avg_hour, i_out_data.avg_hour);
                    check_field("avg_window", reading.avg_window, i_out_data.avg_window);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                amount_ext = {{(COUNT_WIDTH-AMOUNT_W){i_in_data.amount[AMOUNT_W-1]}},
                              i_in_data.amount};
                event_count = event_count + amount_ext;
                if (i_in_data.tick) begin
                    rate = minute_rate(event_count - tick_count, cfg.rate_scale);
                    level[AVG_MINUTE] = ema_step(level[AVG_MINUTE], rate, cfg.weight_minute);
                    level[AVG_TEN] = ema_step(level[AVG_TEN], rate, cfg.weight_ten_minutes);
                    level[AVG_HOUR] = ema_step(level[AVG_HOUR], rate, cfg.weight_hour);
                    if (cfg.window_enable) begin
                        level[AVG_WINDOW] = ema_step(level[AVG_WINDOW], rate, cfg.weight_window);
                    end
                    tick_count = event_count;
                end
                reading.count_value = event_count;
                reading.avg_minute = level[AVG_MINUTE][AVG_W-1:0];
                reading.avg_ten_minutes = level[AVG_TEN][AVG_W-1:0];
                reading.avg_hour = level[AVG_HOUR][AVG_W-1:0];
                reading.avg_window = level[AVG_WINDOW][AVG_W-1:0];
                meter_readings_q.push_back(reading);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RATE_SCALE: cfg.rate_scale = i_cfg_data;
                    CFG_WEIGHT_MINUTE: cfg.weight_minute = i_cfg_data;
                    CFG_WEIGHT_TEN: cfg.weight_ten_minutes = i_cfg_data;
                    CFG_WEIGHT_HOUR: cfg.weight_hour = i_cfg_data;
                    CFG_WEIGHT_WINDOW: cfg.weight_window = i_cfg_data;
                    CFG_WINDOW_ENABLE: cfg.window_enable = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_pending <= meter_readings_q.size();
        o_mismatches <= mismatch_total;
    end

endmodule

/* verif/tb.sv */
// Testbench top for the event rate EMA meter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb import erm_pkg::*; ();

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic signed [AMOUNT_W-1:0] AMOUNT_MAX = {1'b0, {(AMOUNT_W-1){1'b1}}};
    localparam logic signed [AMOUNT_W-1:0] AMOUNT_MIN = {1'b1, {(AMOUNT_W-1){1'b0}}};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_item              in_data = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_RATE_SCALE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_out_item             out_data;
    int                    mismatches;
    int                    pending;
    int                    feed_gap_pct = 20;
    int                    drain_stall_pct = 20;

    always #4 clk = ~clk;

    event_rate_ema_meter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    erm_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial forever begin
        @(posedge clk);
        if ($urandom_range(0, 99) < drain_stall_pct) begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    task automatic push_item(logic signed [AMOUNT_W-1:0] amount, logic tick);
        t_in_item item;
        if ($urandom_range(0, 99) < feed_gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        item.amount = amount;
        item.tick = tick;
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (in_stall);
    endtask

    // hold input until every reading is back and the back end is quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_config(logic [CFG_DATA_W-1:0] scale, logic [CFG_DATA_W-1:0] w_minute,
                                logic [CFG_DATA_W-1:0] w_ten, logic [CFG_DATA_W-1:0] w_hour,
                                logic [CFG_DATA_W-1:0] w_window, logic enable, logic stray);
        cfg_we <= 1'b1;
        cfg_index <= CFG_RATE_SCALE;
        cfg_data <= scale;
        @(posedge clk);
        cfg_index <= CFG_WEIGHT_MINUTE;
        cfg_data <= w_minute;
        @(posedge clk);
        cfg_index <= CFG_WEIGHT_TEN;
        cfg_data <= w_ten;
        @(posedge clk);
        cfg_index <= CFG_WEIGHT_HOUR;
        cfg_data <= w_hour;
        @(posedge clk);
        cfg_index <= CFG_WEIGHT_WINDOW;
        cfg_data <= w_window;
        @(posedge clk);
        cfg_index <= CFG_WINDOW_ENABLE;
        cfg_data <= CFG_DATA_W'(enable);
        @(posedge clk);
        if (stray) begin
            cfg_index <= CFG_UNUSED;
            cfg_data <= CFG_DATA_W'($urandom);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic program_random(logic enable);
        write_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                     CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), enable, 1'b0);
    endtask

    task automatic random_items(int count, int tick_pct);
        logic signed [AMOUNT_W-1:0] amount;
        int                         shape;
        repeat (count) begin
            shape = $urandom_range(0, 9);
            case (shape)
                0, 1, 2, 3, 4, 5: amount = int'($urandom_range(0, 2000)) - 1000;
                6, 7: amount = $urandom;
                8: amount = AMOUNT_MAX;
                default: amount = AMOUNT_MIN;
            endcase
            push_item(amount, $urandom_range(0, 99) < tick_pct);
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        push_item(0, 1'b0);
        push_item(0, 1'b1);
        push_item(AMOUNT_MAX, 1'b0);
        push_item(AMOUNT_MIN, 1'b0);
        push_item(1, 1'b1);
        push_item(-1, 1'b1);
        repeat (3) push_item(AMOUNT_MAX, 1'b0);
        push_item(AMOUNT_MAX, 1'b1);
        repeat (4) push_item(AMOUNT_MIN, 1'b0);
        push_item(AMOUNT_MIN, 1'b1);
        push_item(0, 1'b1);
        push_item(AMOUNT_MAX, 1'b1);
        push_item(AMOUNT_MIN, 1'b1);
        push_item(0, 1'b1);
        push_item(-7, 1'b0);
        push_item(7, 1'b1);

        settle();
        write_config('0, '0, '0, '0, '0, 1'b1, 1'b1);
        random_items(200, 15);

        settle();
        write_config('1, '1, '1, '1, '1, 1'b1, 1'b0);
        random_items(200, 15);

        settle();
        write_config(RESET_RATE_SCALE, RESET_WEIGHT_MINUTE, RESET_WEIGHT_TEN,
                     RESET_WEIGHT_HOUR, CFG_DATA_W'($urandom), 1'b1, 1'b0);
        random_items(200, 12);

        settle();
        feed_gap_pct = 40;
        drain_stall_pct = 40;
        program_random($urandom_range(0, 1));
        random_items(200, 20);

        // drive large positive and negative deltas so the rate saturates
        settle();
        feed_gap_pct = 0;
        drain_stall_pct = 0;
        write_config('1, '1, 16'd1, 16'd32768, '1, 1'b1, 1'b0);
        repeat (3) begin
            repeat (24) push_item(AMOUNT_MAX, 1'b0);
            push_item(AMOUNT_MAX, 1'b1);
            repeat (24) push_item(AMOUNT_MIN, 1'b0);
            push_item(AMOUNT_MIN, 1'b1);
        end

        settle();
        feed_gap_pct = 20;
        drain_stall_pct = 20;
        program_random(1'b0);
        random_items(200, 12);

        settle();
        feed_gap_pct = 0;
        drain_stall_pct = 0;
        program_random(1'b1);
        random_items(300, 12);

        settle();
        if (mismatches == 0 && pending == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/erm_pkg.sv
rtl/erm_front.sv
rtl/erm_queue.sv
rtl/erm_back.sv
rtl/event_rate_ema_meter.sv
verif/erm_checker.sv
verif/tb.sv
